[design/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the checksummed frame receiver
// Holds the result layout, the status codes, the framing byte values and
// the checksum step used by the receive core.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Frame status codes carried in a status result.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ACK       = 4'd1,
    ST_PANEL     = 4'd2,
    ST_BAD_CHECK = 4'd3,
    ST_BAD_LEN   = 4'd4,
    ST_BUSY      = 4'd5,
    ST_BAD_FRAME = 4'd6,
    ST_SHORT     = 4'd7,
    ST_OVERFLOW  = 4'd8
  } status_t;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Framing byte values.
  localparam logic [7:0] BYTE_FE     = 8'hFE;
  localparam logic [7:0] BYTE_F0     = 8'hF0;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_EF     = 8'hEF;
  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_BUSY   = 8'd16;

  // Checksum seed and inversion mask.
  localparam logic [15:0] CHECK_SEED = 16'h147A;
  localparam logic [15:0] CHECK_MASK = 16'hFFFF;

  // Kept positions that matter to the frame layout.
  localparam int unsigned POS_FIRST_PAYLOAD  = 2;
  localparam int unsigned POS_SECOND_PAYLOAD = 3;
  localparam int unsigned POS_RELEASE        = 6;

  // Largest answer length that fits the result field.
  localparam logic [6:0] LEN_MAX = 7'd127;

  // Result queue geometry; the input side stalls while the queue cannot
  // absorb two more requests in flight, each of up to two results.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;
  localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 4);

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    status_t    frame_status;
    logic [7:0] panel_error_code;
    logic [6:0] answer_length;
    logic       last;
  } result_t;

  // Results produced by one processed byte, handed to the queue.
  typedef struct packed {
    logic    wr0;
    logic    wr1;
    result_t res0;
    result_t res1;
  } push_t;

  // One checksum step: rotate left, invert, add high byte and data byte.
  function automatic logic [15:0] check_update(input logic [15:0] c,
                                               input logic [7:0] b);
    logic [15:0] r;
    r = {c[14:0], c[15]} ^ CHECK_MASK;
    return r + {8'h00, r[15:8]} + {8'h00, b};
  endfunction

endpackage

[design/cfr_if.sv]
// ----------------------------------------------------------------------------
// cfr_if: channel interfaces of the checksummed frame receiver
// rx_if carries received bytes in; res_if carries result items out.
// ----------------------------------------------------------------------------
interface rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [3:0] frame_status;
  logic [7:0] panel_error_code;
  logic [6:0] answer_length;
  logic       last;

  modport source (output valid, output kind, output data_byte, output frame_status,
                  output panel_error_code, output answer_length, output last,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input frame_status,
                input panel_error_code, input answer_length, input last,
                output ready);
endinterface

[design/cfr_frame_core.sv]
// ----------------------------------------------------------------------------
// cfr_frame_core: unstuffing, delay line, checksum and frame checks
// Registers each accepted byte, then in the following cycle updates the
// frame state and forms the payload and status results for that byte.
// ----------------------------------------------------------------------------
module cfr_frame_core #(
  parameter int unsigned MAX_RAW_BYTES = 131
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  input  logic              in_eof,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output cfr_pkg::push_t    push
);
  import cfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_RAW_BYTES + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RAW_BYTES);

  // Input register.
  logic       hq_valid;
  logic [7:0] hq_byte;
  logic       hq_eof;

  // Frame state.
  logic [6:0]       expected_length;
  logic             prev_raw_was_fe;
  logic [CNT_W-1:0] raw_count;
  logic [CNT_W-1:0] kept_count;
  logic [7:0]       delay_bytes [4];
  logic [15:0]      running_check;
  logic [7:0]       first_byte;
  logic             prefix_good;
  logic [7:0]       first_payload;
  logic [7:0]       second_payload;

  // Updated values before the end-of-frame clear.
  logic             drop;
  logic             release_byte;
  logic [CNT_W-1:0] raw_count_next;
  logic [CNT_W-1:0] kept_count_next;
  logic [7:0]       delay_bytes_next [4];
  logic [15:0]      running_check_next;
  logic [7:0]       first_byte_next;
  logic             prefix_good_next;
  logic [7:0]       first_payload_next;
  logic [7:0]       second_payload_next;

  logic [CMP_W-1:0] pay;
  logic [6:0]       pay_sat;
  status_t          status;
  logic [7:0]       code;
  logic [6:0]       len;
  result_t          pay_res;
  result_t          stat_res;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hq_valid <= 1'b0;
    end else begin
      hq_valid <= in_accept;
    end
    if (in_accept) begin
      hq_byte <= in_byte;
      hq_eof  <= in_eof;
    end
  end

  // Byte handling: unstuffing, counts, prefix capture, delay line and checksum.
  always_comb begin
    drop = prev_raw_was_fe && (hq_byte == BYTE_F0);
    raw_count_next = (raw_count < CNT_MAX) ? raw_count + CNT_W'(1) : raw_count;
    kept_count_next = kept_count;
    first_byte_next = first_byte;
    prefix_good_next = prefix_good;
    first_payload_next = first_payload;
    second_payload_next = second_payload;
    running_check_next = running_check;
    release_byte = 1'b0;
    for (int i = 0; i < 4; i++) begin
      delay_bytes_next[i] = delay_bytes[i];
    end
    if (!drop) begin
      if (kept_count == CNT_W'(0)) begin
        first_byte_next = hq_byte;
      end else if (kept_count == CNT_W'(1)) begin
        prefix_good_next = (first_byte == BYTE_FE) && (hq_byte == BYTE_FE);
      end
      if (kept_count == CNT_W'(POS_FIRST_PAYLOAD)) begin
        first_payload_next = hq_byte;
      end else if (kept_count == CNT_W'(POS_SECOND_PAYLOAD)) begin
        second_payload_next = hq_byte;
      end
      if (kept_count >= CNT_W'(POS_FIRST_PAYLOAD)) begin
        if (kept_count >= CNT_W'(POS_RELEASE)) begin
          release_byte = 1'b1;
          running_check_next = check_update(running_check, delay_bytes[0]);
        end
        delay_bytes_next[0] = delay_bytes[1];
        delay_bytes_next[1] = delay_bytes[2];
        delay_bytes_next[2] = delay_bytes[3];
        delay_bytes_next[3] = hq_byte;
      end
      if (kept_count < CNT_MAX) begin
        kept_count_next = kept_count + CNT_W'(1);
      end
    end
  end

  // Frame checks on the updated state, in order of precedence.
  always_comb begin
    pay = (kept_count_next > CNT_W'(POS_RELEASE)) ?
          CMP_W'(kept_count_next) - CMP_W'(POS_RELEASE) : '0;
    pay_sat = (pay > CMP_W'(LEN_MAX)) ? LEN_MAX : pay[6:0];
    code = BYTE_ZERO;
    len = 7'd0;
    if (raw_count_next >= CNT_MAX) begin
      status = ST_OVERFLOW;
    end else if (kept_count_next <= CNT_W'(POS_RELEASE)) begin
      status = ST_SHORT;
    end else if (!(prefix_good_next && delay_bytes_next[2] == BYTE_FE &&
                   delay_bytes_next[3] == BYTE_CR)) begin
      status = (first_byte_next == BYTE_BUSY) ? ST_BUSY : ST_BAD_FRAME;
    end else if (first_payload_next != BYTE_EF &&
                 pay != CMP_W'(expected_length)) begin
      status = ST_BAD_LEN;
      len = pay_sat;
    end else if (delay_bytes_next[0] != running_check_next[15:8] ||
                 delay_bytes_next[1] != running_check_next[7:0]) begin
      status = ST_BAD_CHECK;
      len = pay_sat;
    end else if (first_payload_next == BYTE_EF) begin
      if (second_payload_next == BYTE_ZERO || second_payload_next == BYTE_FF) begin
        status = ST_ACK;
      end else begin
        status = ST_PANEL;
        code = second_payload_next;
        len = pay_sat;
      end
    end else begin
      status = ST_OK;
      len = pay_sat;
    end
  end

  // Result forming: a released payload byte comes before the status.
  always_comb begin
    pay_res = '{kind: KIND_PAYLOAD, data_byte: delay_bytes[0], frame_status: ST_OK,
                panel_error_code: BYTE_ZERO, answer_length: 7'd0, last: !hq_eof};
    stat_res = '{kind: KIND_STATUS, data_byte: BYTE_ZERO, frame_status: status,
                 panel_error_code: code, answer_length: len, last: 1'b1};
    push.wr0 = hq_valid && (release_byte || hq_eof);
    push.wr1 = hq_valid && release_byte && hq_eof;
    push.res0 = release_byte ? pay_res : stat_res;
    push.res1 = stat_res;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 7'd0;
    end else if (cfg_we) begin
      expected_length <= cfg_wdata;
    end
  end

  // Frame state register; the end-of-frame byte returns it to reset values.
  always_ff @(posedge clk) begin
    if (rst || (hq_valid && hq_eof)) begin
      prev_raw_was_fe <= 1'b0;
      raw_count <= '0;
      kept_count <= '0;
      for (int i = 0; i < 4; i++) begin
        delay_bytes[i] <= BYTE_ZERO;
      end
      running_check <= CHECK_SEED;
      first_byte <= BYTE_ZERO;
      prefix_good <= 1'b0;
      first_payload <= BYTE_ZERO;
      second_payload <= BYTE_ZERO;
    end else if (hq_valid) begin
      prev_raw_was_fe <= (hq_byte == BYTE_FE);
      raw_count <= raw_count_next;
      kept_count <= kept_count_next;
      for (int i = 0; i < 4; i++) begin
        delay_bytes[i] <= delay_bytes_next[i];
      end
      running_check <= running_check_next;
      first_byte <= first_byte_next;
      prefix_good <= prefix_good_next;
      first_payload <= first_payload_next;
      second_payload <= second_payload_next;
    end
  end

endmodule

[design/cfr_result_fifo.sv]
// ----------------------------------------------------------------------------
// cfr_result_fifo: result queue of the checksummed frame receiver
// Takes up to two results a cycle from the core and hands them out one per
// request on the result channel. Signals room for more input bytes.
// ----------------------------------------------------------------------------
module cfr_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  cfr_pkg::push_t push,
  output logic           room,
  res_if.source          res
);
  import cfr_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] head;
  logic [FIFO_PTR_W-1:0] tail;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic [FIFO_PTR_W-1:0] tail_next;
  logic                  pop;
  result_t               out_res;

  // Occupancy bookkeeping.
  always_comb begin
    pop = res.valid && res.ready;
    tail_next = tail + FIFO_PTR_W'(push.wr0) + FIFO_PTR_W'(push.wr1);
    count_next = count + FIFO_CNT_W'(push.wr0) + FIFO_CNT_W'(push.wr1) -
                 FIFO_CNT_W'(pop);
    room = (count <= FIFO_ROOM_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      tail <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head + FIFO_PTR_W'(1);
      end
    end
  end

  // Storage writes: the second result goes to the slot after the first.
  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem[tail] <= push.res0;
    end
    if (push.wr1) begin
      mem[tail + FIFO_PTR_W'(1)] <= push.res1;
    end
  end

  // Head entry drives the result channel.
  always_comb begin
    out_res = mem[head];
    res.valid = (count != '0);
    res.kind = out_res.kind;
    res.data_byte = out_res.data_byte;
    res.frame_status = out_res.frame_status;
    res.panel_error_code = out_res.panel_error_code;
    res.answer_length = out_res.answer_length;
    res.last = out_res.last;
  end

endmodule

[design/checksummed_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_unit: top level of the frame receiver
// Unstuffs received bytes, releases payload bytes, checks a frame's
// framing, length and checksum, and reports one status per frame.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock cycle while the result queue
// has room. Each byte's work is a single pass between an input register and a
// result queue: the byte is held in the input register and its results are
// written into the queue, which offers them on the result channel. A byte
// gives at most two results (a released payload byte, then the status at
// frame end); the channel hands out one per cycle while the receiver is ready,
// so an end-of-frame byte that also releases a payload byte yields them in
// turn. The input stalls while the eight-entry queue holds over four results.
// Write expected_length only while no frame byte is in flight.
module checksummed_frame_receiver_unit #(
  parameter int unsigned MAX_RAW_BYTES = 131
) (
  input  logic       clk,
  input  logic       rst,
  rx_if.sink         rx,
  res_if.source      res,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);
  import cfr_pkg::*;

  logic  room;
  logic  in_accept;
  push_t push;

  // Input handshake.
  assign rx.ready = room;
  assign in_accept = rx.valid && room;

  cfr_frame_core #(
    .MAX_RAW_BYTES(MAX_RAW_BYTES)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .in_accept(in_accept),
    .in_byte(rx.rx_byte),
    .in_eof(rx.end_of_frame),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push)
  );

  cfr_result_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .room(room),
    .res(res)
  );

endmodule
